/* rtl/rtc_pkg.sv */
// Package for the rigid transform combine core: widths, ops, sequencer states.
// No dependencies.
package rtc_pkg;

  localparam int PosW = 24;
  localparam int SclW = 16;
  localparam int RotW = 16;
  localparam int AccW = 56;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_COMBINE = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WORK,
    ST_OUT
  } state_t;

  // Signed saturation of a wide accumulator to a narrow field.
  function automatic logic [PosW-1:0] sat_pos(input logic signed [AccW-1:0] v);
    if (v > 56'sd8388607) begin
      sat_pos = 24'h7fffff;
    end else if (v < -56'sd8388608) begin
      sat_pos = 24'h800000;
    end else begin
      sat_pos = v[PosW-1:0];
    end
  endfunction

  function automatic logic [SclW-1:0] sat16(input logic signed [AccW-1:0] v);
    if (v > 56'sd32767) begin
      sat16 = 16'h7fff;
    end else if (v < -56'sd32768) begin
      sat16 = 16'h8000;
    end else begin
      sat16 = v[SclW-1:0];
    end
  endfunction

endpackage

/* rtl/rigid_transform_combine_core.sv */
// Rigid transform combine core: one shared multiply-accumulate under a step sequencer.
// Depends on rtc_pkg.
//
// An op 1 or op 2 beat runs 37 multiply-accumulate steps from accept to result valid,
// one per cycle through the single shared multiplier. Op 0 and the unused op finish
// at accept with no result; the block accepts no beat while busy or while a result waits.
// Reset: synchronous; parent becomes identity (pos 0, scale one, rot w one).
module rigid_transform_combine_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // op, local_pos_x/y/z, local_scale_x/y/z, local_rot_x/y/z/w from bit 0 up
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // world_pos_x/y/z, world_scale_x/y/z, world_rot_x/y/z/w from bit 0 up
  output logic [183:0] m_tdata
);
  import rtc_pkg::*;

  state_t state, state_next;
  logic [5:0] step;
  logic       adv;

  // parent and local registers
  logic signed [PosW-1:0] pp [3];
  logic signed [SclW-1:0] ps [3];
  logic signed [RotW-1:0] pr [4];
  logic signed [PosW-1:0] lp [3];
  logic signed [SclW-1:0] ls [3];
  logic signed [RotW-1:0] lr [4];
  // intermediates
  logic signed [39:0] v [3];
  logic signed [39:0] t [3];
  logic signed [AccW-1:0] acc;
  logic [PosW-1:0] wp [3];
  logic [SclW-1:0] ws [3];
  logic [RotW-1:0] wr [4];

  // multiplier operands chosen by step: ma is the wide one, mb always a 16-bit field
  logic signed [39:0] ma;
  logic signed [15:0] mb;
  logic signed [AccW-1:0] prod, acc_in, acc_sum;
  logic neg, first;
  logic [4:0] shamt;

  logic [1:0] in_op;
  assign in_op = s_tdata[1:0];

  // step table: each step does acc = (first ? 0 : acc) +/- ma*mb
  always_comb begin
    ma = '0; mb = '0; neg = 1'b0; first = 1'b0; shamt = 5'd0;
    case (step)
      6'd0:  begin ma = 40'(ps[0]); mb = ls[0]; first = 1; shamt = 5'd8; end
      6'd1:  begin ma = 40'(ps[1]); mb = ls[1]; first = 1; shamt = 5'd8; end
      6'd2:  begin ma = 40'(ps[2]); mb = ls[2]; first = 1; shamt = 5'd8; end
      6'd3:  begin ma = 40'(pr[3]); mb = lr[0]; first = 1; end
      6'd4:  begin ma = 40'(pr[0]); mb = lr[3]; end
      6'd5:  begin ma = 40'(pr[1]); mb = lr[2]; end
      6'd6:  begin ma = 40'(pr[2]); mb = lr[1]; neg = 1; shamt = 5'd14; end
      6'd7:  begin ma = 40'(pr[3]); mb = lr[1]; first = 1; end
      6'd8:  begin ma = 40'(pr[0]); mb = lr[2]; neg = 1; end
      6'd9:  begin ma = 40'(pr[1]); mb = lr[3]; end
      6'd10: begin ma = 40'(pr[2]); mb = lr[0]; shamt = 5'd14; end
      6'd11: begin ma = 40'(pr[3]); mb = lr[2]; first = 1; end
      6'd12: begin ma = 40'(pr[0]); mb = lr[1]; end
      6'd13: begin ma = 40'(pr[1]); mb = lr[0]; neg = 1; end
      6'd14: begin ma = 40'(pr[2]); mb = lr[3]; shamt = 5'd14; end
      6'd15: begin ma = 40'(pr[3]); mb = lr[3]; first = 1; end
      6'd16: begin ma = 40'(pr[0]); mb = lr[0]; neg = 1; end
      6'd17: begin ma = 40'(pr[1]); mb = lr[1]; neg = 1; end
      6'd18: begin ma = 40'(pr[2]); mb = lr[2]; neg = 1; shamt = 5'd14; end
      6'd19: begin ma = 40'(lp[0]); mb = ps[0]; first = 1; shamt = 5'd8; end
      6'd20: begin ma = 40'(lp[1]); mb = ps[1]; first = 1; shamt = 5'd8; end
      6'd21: begin ma = 40'(lp[2]); mb = ps[2]; first = 1; shamt = 5'd8; end
      // t = cross(q, v) >> 13
      6'd22: begin ma = v[2]; mb = pr[1]; first = 1; end
      6'd23: begin ma = v[1]; mb = pr[2]; neg = 1; shamt = 5'd13; end
      6'd24: begin ma = v[0]; mb = pr[2]; first = 1; end
      6'd25: begin ma = v[2]; mb = pr[0]; neg = 1; shamt = 5'd13; end
      6'd26: begin ma = v[1]; mb = pr[0]; first = 1; end
      6'd27: begin ma = v[0]; mb = pr[1]; neg = 1; shamt = 5'd13; end
      // r = cross(q, t) >> 14, then add t*w >> 14, v and parent position
      6'd28: begin ma = t[2]; mb = pr[1]; first = 1; end
      6'd29: begin ma = t[1]; mb = pr[2]; neg = 1; shamt = 5'd14; end
      6'd30: begin ma = t[0]; mb = pr[3]; first = 1; shamt = 5'd14; end
      6'd31: begin ma = t[0]; mb = pr[2]; first = 1; end
      6'd32: begin ma = t[2]; mb = pr[0]; neg = 1; shamt = 5'd14; end
      6'd33: begin ma = t[1]; mb = pr[3]; first = 1; shamt = 5'd14; end
      6'd34: begin ma = t[1]; mb = pr[0]; first = 1; end
      6'd35: begin ma = t[0]; mb = pr[1]; neg = 1; shamt = 5'd14; end
      6'd36: begin ma = t[2]; mb = pr[3]; first = 1; shamt = 5'd14; end
      default: ;
    endcase
  end

  // shared multiply-accumulate; v and t stay below 2^34, so 40 by 16 bits covers every step
  assign prod = AccW'(ma * mb);
  assign acc_in = first ? '0 : acc;
  assign acc_sum = neg ? acc_in - prod : acc_in + prod;

  // floor shift of the finished term
  logic signed [AccW-1:0] shr;
  assign shr = acc_sum >>> shamt;

  // accumulated position partial: r + v + parent position; tw is added into the pos register below
  logic signed [AccW-1:0] pacc [3];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid && (in_op == OP_COMBINE || in_op == OP_ADVANCE)) begin
        state_next = ST_WORK;
      end
      ST_WORK: if (step == 6'd36) state_next = ST_OUT;
      ST_OUT:  if (m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    m_tvalid = (state == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      for (int i = 0; i < 3; i++) begin
        pp[i] <= '0;
        ps[i] <= 16'sd256;
      end
      for (int i = 0; i < 3; i++) pr[i] <= '0;
      pr[3] <= 16'sd16384;
      adv <= 1'b0;
    end else begin
      state <= state_next;
      // capture a beat
      if (state == ST_IDLE && s_tvalid) begin
        step <= '0;
        adv <= (in_op == OP_ADVANCE);
        if (in_op == OP_LOAD) begin
          for (int i = 0; i < 3; i++) begin
            pp[i] <= s_tdata[2 + 24*i +: 24];
            ps[i] <= s_tdata[74 + 16*i +: 16];
          end
          for (int i = 0; i < 4; i++) pr[i] <= s_tdata[122 + 16*i +: 16];
        end
      end
      if (state == ST_WORK) step <= step + 6'd1;
      // advance parent after delivery
      if (state == ST_OUT && m_tready && adv) begin
        for (int i = 0; i < 3; i++) begin
          pp[i] <= wp[i];
          ps[i] <= ws[i];
        end
        for (int i = 0; i < 4; i++) pr[i] <= wr[i];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      for (int i = 0; i < 3; i++) begin
        lp[i] <= s_tdata[2 + 24*i +: 24];
        ls[i] <= s_tdata[74 + 16*i +: 16];
      end
      for (int i = 0; i < 4; i++) lr[i] <= s_tdata[122 + 16*i +: 16];
    end
    if (state == ST_WORK) begin
      acc <= acc_sum;
      case (step)
        6'd0:  ws[0] <= sat16(shr);
        6'd1:  ws[1] <= sat16(shr);
        6'd2:  ws[2] <= sat16(shr);
        6'd6:  wr[0] <= sat16(shr);
        6'd10: wr[1] <= sat16(shr);
        6'd14: wr[2] <= sat16(shr);
        6'd18: wr[3] <= sat16(shr);
        6'd19: v[0] <= shr[39:0];
        6'd20: v[1] <= shr[39:0];
        6'd21: v[2] <= shr[39:0];
        6'd23: t[0] <= shr[39:0];
        6'd25: t[1] <= shr[39:0];
        6'd27: t[2] <= shr[39:0];
        6'd29: pacc[0] <= shr + AccW'(v[0]) + AccW'(pp[0]);
        6'd30: wp[0] <= sat_pos(pacc[0] + shr);
        6'd32: pacc[1] <= shr + AccW'(v[1]) + AccW'(pp[1]);
        6'd33: wp[1] <= sat_pos(pacc[1] + shr);
        6'd35: pacc[2] <= shr + AccW'(v[2]) + AccW'(pp[2]);
        6'd36: wp[2] <= sat_pos(pacc[2] + shr);
        default: ;
      endcase
    end
  end

  assign m_tdata = {wr[3], wr[2], wr[1], wr[0], ws[2], ws[1], ws[0],
                    wp[2], wp[1], wp[0]};

endmodule

/* dv/rigid_transform_combine_core_tb.sv */
// Self-checking bench for rigid_transform_combine_core: directed and random transform beats
// go through a bit-exact fixed-point predictor of the parent/local combination.
// Depends on rtc_pkg and the core RTL.
module rigid_transform_combine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rtc_pkg::*;

  typedef struct {
    logic signed [23:0] pos[3];
    logic signed [15:0] scl[3];
    logic signed [15:0] rot[4];
  } xform_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [183:0] m_tdata;

  xform_t world_q[$];
  xform_t parent;
  int     mismatches = 0;
  int     failures = 0;
  int     beats_sent = 0;
  int     combines_seen = 0;
  bit     no_idle = 1'b0;

  rigid_transform_combine_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #2 clk = ~clk;

  // Clamp to a signed field of width w.
  function automatic longint clamp(input longint v, input int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic xform_t identity_xform();
    xform_t x;
    for (int i = 0; i < 3; i++) begin
      x.pos[i] = '0;
      x.scl[i] = 16'sd256;
    end
    x.rot[0] = '0; x.rot[1] = '0; x.rot[2] = '0;
    x.rot[3] = 16'sd16384;
    return x;
  endfunction

  // Combine parent and local: per-axis scale, Hamilton product, scaled/rotated/offset position.
  function automatic xform_t combine(input xform_t p, input xform_t l);
    xform_t o;
    longint px, py, pz, pw, lx, ly, lz, lw;
    longint v[3], t[3], c[3], r[3];
    px = p.rot[0]; py = p.rot[1]; pz = p.rot[2]; pw = p.rot[3];
    lx = l.rot[0]; ly = l.rot[1]; lz = l.rot[2]; lw = l.rot[3];
    for (int i = 0; i < 3; i++)
      o.scl[i] = clamp((longint'(p.scl[i]) * longint'(l.scl[i])) >>> 8, 16);
    o.rot[0] = clamp((pw*lx + px*lw + py*lz - pz*ly) >>> 14, 16);
    o.rot[1] = clamp((pw*ly - px*lz + py*lw + pz*lx) >>> 14, 16);
    o.rot[2] = clamp((pw*lz + px*ly - py*lx + pz*lw) >>> 14, 16);
    o.rot[3] = clamp((pw*lw - px*lx - py*ly - pz*lz) >>> 14, 16);
    for (int i = 0; i < 3; i++)
      v[i] = (longint'(l.pos[i]) * longint'(p.scl[i])) >>> 8;
    c[0] = py*v[2] - pz*v[1];
    c[1] = pz*v[0] - px*v[2];
    c[2] = px*v[1] - py*v[0];
    for (int i = 0; i < 3; i++) t[i] = c[i] >>> 13;
    c[0] = py*t[2] - pz*t[1];
    c[1] = pz*t[0] - px*t[2];
    c[2] = px*t[1] - py*t[0];
    for (int i = 0; i < 3; i++) begin
      r[i] = c[i] >>> 14;
      o.pos[i] = clamp(((t[i] * pw) >>> 14) + r[i] + v[i] + longint'(p.pos[i]), 24);
    end
    return o;
  endfunction

  function automatic logic [191:0] pack_beat(input op_t op, input xform_t l);
    logic [191:0] d;
    d = '0;
    d[1:0] = op;
    for (int i = 0; i < 3; i++) begin
      d[2 + 24*i +: 24] = l.pos[i];
      d[74 + 16*i +: 16] = l.scl[i];
    end
    for (int i = 0; i < 4; i++) d[122 + 16*i +: 16] = l.rot[i];
    return d;
  endfunction

  function automatic xform_t unpack_world(input logic [183:0] d);
    xform_t x;
    for (int i = 0; i < 3; i++) begin
      x.pos[i] = d[24*i +: 24];
      x.scl[i] = d[72 + 16*i +: 16];
    end
    for (int i = 0; i < 4; i++) x.rot[i] = d[120 + 16*i +: 16];
    return x;
  endfunction

  // Random field value: extremes, small magnitudes or full range.
  function automatic logic [23:0] rand_field(input int w);
    logic [23:0] m;
    m = (24'hffffff >> (24 - w));
    case ($urandom_range(0, 9))
      0: return m >> 1;
      1: return ~(m >> 1) & m;
      2: return m;
      3: return 24'd0;
      4, 5: return $urandom_range(0, 1023) - 512;
      default: return $urandom & m;
    endcase
  endfunction

  function automatic xform_t rand_xform();
    xform_t x;
    for (int i = 0; i < 3; i++) begin
      x.pos[i] = rand_field(24);
      x.scl[i] = rand_field(16);
    end
    for (int i = 0; i < 4; i++) x.rot[i] = rand_field(16);
    return x;
  endfunction

  function automatic xform_t fill_xform(input longint pv, input longint sv, input longint rv);
    xform_t x;
    for (int i = 0; i < 3; i++) begin
      x.pos[i] = pv;
      x.scl[i] = sv;
    end
    for (int i = 0; i < 4; i++) x.rot[i] = rv;
    return x;
  endfunction

  // Send one beat after a random gap; update the parent model on accept.
  task automatic send_beat(input op_t op, input xform_t l);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= pack_beat(op, l);
    do @(posedge clk); while (!s_tready);
    beats_sent++;
    case (op)
      OP_LOAD: parent = l;
      OP_COMBINE: world_q.push_back(combine(parent, l));
      OP_ADVANCE: begin
        world_q.push_back(combine(parent, l));
        parent = world_q[$];
      end
      default: ;
    endcase
  endtask

  task automatic end_burst();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // Hold the sender until every expected result has drained.
  task automatic drain();
    end_burst();
    while (world_q.size() != 0) @(posedge clk);
  endtask

  // Receiver stalls: random hold-off before each result beat.
  initial begin
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 17);
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
        @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready) || rst);
    end
  end

  // Compare each result beat with the oldest prediction.
  task automatic check_world(input logic [183:0] d);
    xform_t got, exp_x;
    got = unpack_world(d);
    combines_seen++;
    if (world_q.size() == 0) begin
      failures++;
      $display("unexpected result beat at %0t", $realtime);
      return;
    end
    exp_x = world_q.pop_front();
    for (int i = 0; i < 10; i++) begin
      longint e, a;
      if (i < 3) begin e = exp_x.pos[i]; a = got.pos[i]; end
      else if (i < 6) begin e = exp_x.scl[i-3]; a = got.scl[i-3]; end
      else begin e = exp_x.rot[i-6]; a = got.rot[i-6]; end
      if (e != a) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d field %0d: expected %0d, got %0d", combines_seen, i, e, a);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_world(m_tdata);
  end

  // Identity parent after reset, extremes, unused op, chains, unnormalized rotations.
  task automatic test_directed();
    send_beat(OP_COMBINE, fill_xform(1000, 512, 8192));
    send_beat(OP_COMBINE, fill_xform(8388607, 32767, 32767));
    send_beat(OP_NONE, fill_xform(-1, -1, -1));
    send_beat(OP_COMBINE, fill_xform(-8388608, -32768, -32768));
    send_beat(OP_LOAD, fill_xform(8388607, 32767, 32767));
    send_beat(OP_COMBINE, fill_xform(8388607, 32767, 32767));
    send_beat(OP_COMBINE, fill_xform(-8388608, -32768, -32768));
    send_beat(OP_LOAD, fill_xform(-8388608, -32768, -32768));
    send_beat(OP_COMBINE, fill_xform(-8388608, -32768, -32768));
    send_beat(OP_COMBINE, fill_xform(1, 1, 1));
    send_beat(OP_LOAD, identity_xform());
    send_beat(OP_ADVANCE, fill_xform(256, 256, 11585));
    send_beat(OP_ADVANCE, fill_xform(-256, 128, 11585));
    send_beat(OP_ADVANCE, fill_xform(300000, 300, -5000));
    send_beat(OP_NONE, fill_xform(0, 0, 0));
    send_beat(OP_COMBINE, fill_xform(0, 0, 0));
    send_beat(OP_LOAD, fill_xform(12345, -700, 30000));
    send_beat(OP_COMBINE, fill_xform(-4000000, 32767, -20000));
    drain();
  endtask

  // Random hierarchy chains with occasional reloads and unused ops.
  task automatic test_random(input int count);
    op_t op;
    for (int n = 0; n < count; n++) begin
      if (n % 300 == 0) no_idle = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 19))
        0, 1: op = OP_LOAD;
        2: op = OP_NONE;
        3, 4, 5, 6, 7, 8, 9, 10: op = OP_COMBINE;
        default: op = OP_ADVANCE;
      endcase
      send_beat(op, rand_xform());
      if (n == count / 2) drain();
    end
    drain();
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    parent = identity_xform();
    test_directed();
    test_random(2000);
    repeat (60) @(posedge clk);
    if (world_q.size() != 0) failures++;
    $display("Sent %0d beats, checked %0d combined transforms (%0d field mismatches).",
             beats_sent, combines_seen, mismatches);
    if (failures == 0 && mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
